>>> rtl/pcx_rle_pkg.sv
// shared types and constants for the pcx line rle encoder
// no dependencies; imported by every module of the block
package pcx_rle_pkg;

	localparam int PIXEL_BITS = 8;
	localparam int RUN_BITS = 6;
	localparam int LW_BITS = 15;
	localparam int DATA_BITS = 32;
	localparam int ADDR_BITS = 3;

	localparam logic [RUN_BITS-1:0] MAX_RUN = 6'd63;
	localparam logic [PIXEL_BITS-1:0] LITERAL_MAX = 8'hBF;
	localparam logic [PIXEL_BITS-1:0] COUNT_FLAG = 8'hC0;
	localparam logic [LW_BITS-1:0] LINE_WIDTH_RESET = 15'd640;

	// register index taken from paddr word bit
	localparam logic REG_LINE_WIDTH = 1'b0;

	// job queue depth, a power of two
	localparam int FIFO_DEPTH = 2;

	// byte slots of one job, sent in this order
	localparam int SLOT_A_COUNT = 0;
	localparam int SLOT_A_VALUE = 1;
	localparam int SLOT_B_COUNT = 2;
	localparam int SLOT_B_VALUE = 3;
	localparam int SLOT_COUNT = 4;

	// one classified pixel: the closed run (a) and the line flush run (b)
	typedef struct packed {
		logic [SLOT_COUNT-1:0] mask;
		logic [PIXEL_BITS-1:0] a_value;
		logic [RUN_BITS-1:0] a_len;
		logic [PIXEL_BITS-1:0] b_value;
		logic [RUN_BITS-1:0] b_len;
		logic eol;
	} job_t;

	// a run needs a count byte unless it is a single low-valued pixel
	function automatic logic count_needed(input logic [RUN_BITS-1:0] len,
			input logic [PIXEL_BITS-1:0] value);
		count_needed = (len > RUN_BITS'(1)) || (value > LITERAL_MAX);
	endfunction

	function automatic logic [PIXEL_BITS-1:0] count_byte(input logic [RUN_BITS-1:0] len);
		count_byte = COUNT_FLAG | PIXEL_BITS'(len);
	endfunction

endpackage

>>> rtl/pcx_rle_front.sv
// front end: tracks the open run and line column, classifies each pixel
// into a job of up to four bytes; uses pcx_rle_pkg
module pcx_rle_front import pcx_rle_pkg::*; #(
	parameter int COLUMN_BITS = 15
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [LW_BITS-1:0]    line_width,
	input  logic [PIXEL_BITS-1:0] pixel,
	input  logic                  take,
	output job_t                  job,
	output logic                  job_push
);

	localparam int CMP_BITS = (COLUMN_BITS >= LW_BITS) ? COLUMN_BITS + 1 : LW_BITS + 1;

	logic [PIXEL_BITS-1:0]  run_value_q;
	logic [RUN_BITS-1:0]    run_length_q;
	logic [COLUMN_BITS-1:0] column_q;

	logic                  extend;
	logic [PIXEL_BITS-1:0] new_value;
	logic [RUN_BITS-1:0]   new_len;
	logic [CMP_BITS-1:0]   width_eff;
	logic [CMP_BITS-1:0]   cap;
	logic [CMP_BITS-1:0]   next_col;
	logic                  eol;

	// effective line width: zero reads as one, capped at the column range
	always_comb begin
		cap = CMP_BITS'(1) << COLUMN_BITS;
		width_eff = CMP_BITS'(line_width);
		if (width_eff == '0) begin
			width_eff = CMP_BITS'(1);
		end
		if (width_eff > cap) begin
			width_eff = cap;
		end
		next_col = CMP_BITS'(column_q) + CMP_BITS'(1);
		eol = (next_col >= width_eff);
	end

	// run classification
	always_comb begin
		extend = (run_length_q != '0) && (pixel == run_value_q) && (run_length_q < MAX_RUN);
		new_value = extend ? run_value_q : pixel;
		new_len = extend ? run_length_q + RUN_BITS'(1) : RUN_BITS'(1);

		job = '0;
		job.a_value = run_value_q;
		job.a_len = run_length_q;
		job.b_value = new_value;
		job.b_len = new_len;
		job.eol = eol;
		if (!extend && run_length_q != '0) begin
			job.mask[SLOT_A_COUNT] = count_needed(run_length_q, run_value_q);
			job.mask[SLOT_A_VALUE] = 1'b1;
		end
		if (eol) begin
			job.mask[SLOT_B_COUNT] = count_needed(new_len, new_value);
			job.mask[SLOT_B_VALUE] = 1'b1;
		end
		job_push = take && (job.mask != '0);
	end

	// run and column state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_value_q <= '0;
			run_length_q <= '0;
			column_q <= '0;
		end else if (take) begin
			run_value_q <= new_value;
			if (eol) begin
				run_length_q <= '0;
				column_q <= '0;
			end else begin
				run_length_q <= new_len;
				column_q <= next_col[COLUMN_BITS-1:0];
			end
		end
	end

endmodule

>>> rtl/pcx_rle_fifo.sv
// short job queue between the front and back ends
// depends on pcx_rle_pkg for job_t and FIFO_DEPTH
module pcx_rle_fifo import pcx_rle_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic head_valid,
	output logic full
);

	localparam int PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_BITS = PTR_BITS + 1;

	job_t                entry_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign head = entry_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full = (count_q == CNT_BITS'(FIFO_DEPTH));

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

endmodule

>>> rtl/pcx_rle_back.sv
// back end: walks the byte slots of the head job, one byte per cycle unless
// the output stalls, into the output register; depends on pcx_rle_pkg
module pcx_rle_back import pcx_rle_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  job_t                  head,
	input  logic                  head_valid,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIXEL_BITS-1:0] code_byte,
	output logic                  last_of_burst,
	output logic                  line_done
);

	logic [SLOT_COUNT-1:0] left_q;
	logic                  started_q;
	logic                  out_valid_q;
	logic [PIXEL_BITS-1:0] code_byte_q;
	logic                  last_q;
	logic                  done_q;

	logic [SLOT_COUNT-1:0] cur_mask;
	logic [SLOT_COUNT-1:0] sel;
	logic [SLOT_COUNT-1:0] rem;
	logic [PIXEL_BITS-1:0] next_byte;
	logic                  fire;

	// pick the lowest pending slot
	always_comb begin
		cur_mask = started_q ? left_q : head.mask;
		sel = cur_mask & (~cur_mask + SLOT_COUNT'(1));
		rem = cur_mask & ~sel;
		fire = head_valid && (!out_valid_q || out_ready);
		pop = fire && (rem == '0);
		priority if (sel[SLOT_A_COUNT]) begin
			next_byte = count_byte(head.a_len);
		end else if (sel[SLOT_A_VALUE]) begin
			next_byte = head.a_value;
		end else if (sel[SLOT_B_COUNT]) begin
			next_byte = count_byte(head.b_len);
		end else begin
			next_byte = head.b_value;
		end
	end

	// slot progress within the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			left_q <= '0;
		end else if (fire) begin
			started_q <= (rem != '0);
			left_q <= rem;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			code_byte_q <= next_byte;
			last_q <= (rem == '0);
			done_q <= (rem == '0) && head.eol;
		end
	end

	assign out_valid = out_valid_q;
	assign code_byte = code_byte_q;
	assign last_of_burst = last_q;
	assign line_done = done_q;

endmodule

>>> rtl/pcx_line_rle_encoder_top.sv
// pcx line rle encoder: 8-bit pixels in, pcx run-length coded bytes out
// path: a pixel's job goes through the job queue, then its first byte into the output register
// throughput: one pixel per cycle while runs extend and the queue has room;
//   a pixel gives 0 to 4 bytes, sent one at a time on the one-byte output port
// reset: asynchronous, clears run state, column, queue; line_width to 640
// depends on pcx_rle_pkg, pcx_rle_front, pcx_rle_fifo, pcx_rle_back
module pcx_line_rle_encoder_top import pcx_rle_pkg::*; #(
	parameter int COLUMN_BITS = 15
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// apb configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_BITS-1:0]  paddr,
	input  logic [DATA_BITS-1:0]  pwdata,
	output logic [DATA_BITS-1:0]  prdata,
	output logic                  pready,
	// pixel channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIXEL_BITS-1:0] pixel,
	// code byte channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIXEL_BITS-1:0] code_byte,
	output logic                  last_of_burst,
	output logic                  line_done
);

	logic [LW_BITS-1:0] line_width_q;
	logic               reg_index;
	logic               take;
	job_t               push_job;
	logic               job_push;
	job_t               head;
	logic               head_valid;
	logic               pop;
	logic               full;

	// configuration register
	assign pready = 1'b1;
	assign reg_index = paddr[ADDR_BITS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RESET;
		end else if (psel && penable && pwrite && pready && reg_index == REG_LINE_WIDTH) begin
			line_width_q <= pwdata[LW_BITS-1:0];
		end
	end

	assign prdata = (reg_index == REG_LINE_WIDTH) ? DATA_BITS'(line_width_q) : '0;

	// pixel beat accepted while the queue has room
	assign in_ready = !full;
	assign take = in_valid && in_ready;

	pcx_rle_front #(
		.COLUMN_BITS(COLUMN_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.line_width(line_width_q),
		.pixel     (pixel),
		.take      (take),
		.job       (push_job),
		.job_push  (job_push)
	);

	pcx_rle_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_job  (push_job),
		.pop       (pop),
		.head      (head),
		.head_valid(head_valid),
		.full      (full)
	);

	pcx_rle_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.code_byte    (code_byte),
		.last_of_burst(last_of_burst),
		.line_done    (line_done)
	);

	// end of line always closes a burst
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_done |-> last_of_burst)
		else $error("line_done without last_of_burst");

	// a burst continues back to back once started
	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_burst |=> out_valid)
		else $error("burst broken before its last beat");

	// a job is never pushed into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !full)
		else $error("job queue overflow");

	// a line end always leaves at least one byte queued
	a_eol_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		take && push_job.eol |-> job_push)
		else $error("line end produced no bytes");

endmodule
